[hw/rtl/dqr_pkg.sv]
// ----------------------------------------------------------------------------
// dqr_pkg - shared types and constants for the deque ring
// Request codes, field widths and the control structs that the controller
// drives into the row of storage cells.
// ----------------------------------------------------------------------------
package dqr_pkg;

  localparam int REQ_W     = 3;
  localparam int DATA_W    = 32;
  localparam int TOTAL_W   = 8;
  localparam int DEPTH_DEF = 128;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_BACK  = 3'd0,
    REQ_PUSH_FRONT = 3'd1,
    REQ_POP_FRONT  = 3'd2,
    REQ_POP_BACK   = 3'd3,
    REQ_PEEK_FRONT = 3'd4,
    REQ_PEEK_BACK  = 3'd5,
    REQ_CLEAR      = 3'd6
  } req_t;

  // ring movement: RIGHT moves cell i-1 into cell i, LEFT moves cell i+1 into cell i
  typedef enum logic [1:0] {
    SH_HOLD  = 2'd0,
    SH_RIGHT = 2'd1,
    SH_LEFT  = 2'd2
  } shift_t;

  typedef struct packed {
    shift_t             shift;
    logic               load_front;
    logic               load_back;
    logic [DATA_W-1:0]  load_data;
  } ring_ctl_t;

  typedef struct packed {
    shift_t shift;
    logic   load;
  } cell_ctl_t;

endpackage

[hw/rtl/dqr_req_if.sv]
// ----------------------------------------------------------------------------
// dqr_req_if - request channel of the deque ring
// valid/ready handshake carrying one request word.
// ----------------------------------------------------------------------------
interface dqr_req_if;
  import dqr_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [REQ_W-1:0]         req_type;
  logic signed [DATA_W-1:0] push_value;

  modport source (output valid, output req_type, output push_value, input ready);
  modport sink   (input valid, input req_type, input push_value, output ready);
endinterface

[hw/rtl/dqr_rsp_if.sv]
// ----------------------------------------------------------------------------
// dqr_rsp_if - result channel of the deque ring
// valid/ready handshake carrying one result word.
// ----------------------------------------------------------------------------
interface dqr_rsp_if;
  import dqr_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     status;
  logic signed [DATA_W-1:0] read_value;
  logic [TOTAL_W-1:0]       entry_total;

  modport source (output valid, output status, output read_value, output entry_total,
                  input ready);
  modport sink   (input valid, input status, input read_value, input entry_total,
                  output ready);
endinterface

[hw/rtl/dqr_cell.sv]
// ----------------------------------------------------------------------------
// dqr_cell - one storage cell of the ring
// Holds one entry; each cycle it keeps it, takes a neighbor's word, or loads
// a new word from the controller.
// ----------------------------------------------------------------------------
module dqr_cell (
  input  logic                      clk,
  input  dqr_pkg::cell_ctl_t        ctl,
  input  logic [dqr_pkg::DATA_W-1:0] left_q,
  input  logic [dqr_pkg::DATA_W-1:0] right_q,
  input  logic [dqr_pkg::DATA_W-1:0] load_data,
  output logic [dqr_pkg::DATA_W-1:0] data_q
);
  import dqr_pkg::*;

  logic [DATA_W-1:0] data_r;
  logic [DATA_W-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (ctl.load) begin
      data_nxt = load_data;
    end else begin
      unique case (ctl.shift)
        SH_HOLD:  data_nxt = data_r;
        SH_RIGHT: data_nxt = left_q;
        SH_LEFT:  data_nxt = right_q;
        default:  data_nxt = data_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_q = data_r;

endmodule

[hw/rtl/dqr_ctrl.sv]
// ----------------------------------------------------------------------------
// dqr_ctrl - request sequencer of the deque ring
// Tracks the entry count and which end the ring is aligned to, rotates the
// ring when a request targets the other end, and holds the result register.
// ----------------------------------------------------------------------------
module dqr_ctrl #(
  parameter int DEPTH = dqr_pkg::DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  dqr_req_if.sink                    in_req,
  dqr_rsp_if.source                  out_rsp,
  input  logic [dqr_pkg::DATA_W-1:0] front_q,
  input  logic [dqr_pkg::DATA_W-1:0] back_q,
  output dqr_pkg::ring_ctl_t         ring_ctl
);
  import dqr_pkg::*;

  localparam int               CNT_W    = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] ONE_CNT  = CNT_W'(1);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_ALIGN = 3'b010,
    S_EXEC  = 3'b100
  } state_t;

  state_t                  state_r, state_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic                    back_mode_r, back_mode_nxt;
  logic [CNT_W-1:0]        steps_r, steps_nxt;
  logic                    dir_left_r, dir_left_nxt;
  logic [REQ_W-1:0]        req_r, req_nxt;
  logic [DATA_W-1:0]       val_r, val_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic                    out_status_r, out_status_nxt;
  logic [DATA_W-1:0]       out_value_r, out_value_nxt;

  logic                    accept;
  logic                    slot_free;
  logic [REQ_W-1:0]        cur_req;
  logic [DATA_W-1:0]       cur_val;
  logic                    is_push, is_take, back_side, code_ok;
  logic                    full, empty, err, need_align;
  logic [CNT_W-1:0]        gap;
  logic                    short_way;
  logic                    exec;
  shift_t                  shift_sel;
  logic                    ld_front, ld_back;
  logic [CNT_W+TOTAL_W-1:0] total_ext;

  assign in_req.ready = (state_r == S_IDLE);
  assign accept       = in_req.valid && in_req.ready;
  assign slot_free    = !out_valid_r || out_rsp.ready;

  assign cur_req = (state_r == S_IDLE) ? in_req.req_type : req_r;
  assign cur_val = (state_r == S_IDLE) ? in_req.push_value : val_r;

  assign is_push   = (cur_req == REQ_PUSH_BACK) || (cur_req == REQ_PUSH_FRONT);
  assign is_take   = (cur_req == REQ_POP_FRONT) || (cur_req == REQ_POP_BACK) ||
                     (cur_req == REQ_PEEK_FRONT) || (cur_req == REQ_PEEK_BACK);
  assign back_side = (cur_req == REQ_PUSH_BACK) || (cur_req == REQ_POP_BACK) ||
                     (cur_req == REQ_PEEK_BACK);
  assign code_ok   = is_push || is_take || (cur_req == REQ_CLEAR);

  assign full  = (count_r == FULL_CNT);
  assign empty = (count_r == '0);
  assign err   = !code_ok || (is_push && full) || (is_take && empty);

  // empty and full rings are aligned to both ends at once
  assign need_align = (is_push || is_take) && !err && (back_side != back_mode_r) &&
                      !empty && !full;

  // rotate the shorter way around: count steps one way, the gap the other
  assign gap       = FULL_CNT - count_r;
  assign short_way = (count_r <= gap);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    back_mode_nxt = back_mode_r;
    steps_nxt     = steps_r;
    dir_left_nxt  = dir_left_r;
    req_nxt       = req_r;
    val_nxt       = val_r;
    out_valid_nxt = out_valid_r && !out_rsp.ready;
    out_status_nxt = out_status_r;
    out_value_nxt = out_value_r;
    shift_sel     = SH_HOLD;
    ld_front      = 1'b0;
    ld_back       = 1'b0;
    exec          = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          req_nxt = in_req.req_type;
          val_nxt = in_req.push_value;
          if (need_align) begin
            state_nxt    = S_ALIGN;
            steps_nxt    = short_way ? count_r : gap;
            // front->back goes left on the short way, back->front goes right
            dir_left_nxt = (back_side == short_way);
          end else if (slot_free) begin
            exec = 1'b1;
          end else begin
            state_nxt = S_EXEC;
          end
        end
      end
      S_ALIGN: begin
        shift_sel = dir_left_r ? SH_LEFT : SH_RIGHT;
        steps_nxt = steps_r - ONE_CNT;
        if (steps_r == ONE_CNT) begin
          state_nxt     = S_EXEC;
          back_mode_nxt = !back_mode_r;
        end
      end
      S_EXEC: begin
        if (slot_free) begin
          exec      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (exec) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = err;
      out_value_nxt  = '0;
      if (!err) begin
        unique case (cur_req)
          REQ_PUSH_BACK: begin
            shift_sel     = SH_LEFT;
            ld_back       = 1'b1;
            count_nxt     = count_r + ONE_CNT;
            back_mode_nxt = 1'b1;
          end
          REQ_PUSH_FRONT: begin
            shift_sel     = SH_RIGHT;
            ld_front      = 1'b1;
            count_nxt     = count_r + ONE_CNT;
            back_mode_nxt = 1'b0;
          end
          REQ_POP_FRONT: begin
            out_value_nxt = front_q;
            shift_sel     = SH_LEFT;
            count_nxt     = count_r - ONE_CNT;
            back_mode_nxt = 1'b0;
          end
          REQ_POP_BACK: begin
            out_value_nxt = back_q;
            shift_sel     = SH_RIGHT;
            count_nxt     = count_r - ONE_CNT;
            back_mode_nxt = 1'b1;
          end
          REQ_PEEK_FRONT: begin
            out_value_nxt = front_q;
            back_mode_nxt = 1'b0;
          end
          REQ_PEEK_BACK: begin
            out_value_nxt = back_q;
            back_mode_nxt = 1'b1;
          end
          REQ_CLEAR: count_nxt = '0;
          default: ;
        endcase
      end
    end
  end

  assign ring_ctl = '{shift: shift_sel, load_front: ld_front, load_back: ld_back,
                      load_data: cur_val};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      back_mode_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      back_mode_r <= back_mode_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    steps_r      <= steps_nxt;
    dir_left_r   <= dir_left_nxt;
    req_r        <= req_nxt;
    val_r        <= val_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
  end

  // count only moves on an execute, which needs the result slot free, so the
  // live count is the total of the word currently held
  assign total_ext = {{TOTAL_W{1'b0}}, count_r};

  assign out_rsp.valid       = out_valid_r;
  assign out_rsp.status      = out_status_r;
  assign out_rsp.read_value  = out_value_r;
  assign out_rsp.entry_total = total_ext[TOTAL_W-1:0];

`ifndef SYNTH
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("entry count above depth");

  a_align_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ALIGN) |-> (steps_r != '0))
    else $error("rotation with no steps left");

  a_one_load: assert property (@(posedge clk) disable iff (!rst_n)
    !(ld_front && ld_back))
    else $error("both ring ends loaded at once");

  a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !exec |=> (count_r == $past(count_r)))
    else $error("count moved without an executed request");

  a_align_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ALIGN) |-> (!empty && !full))
    else $error("rotation on an empty or full ring");
`endif

endmodule

[hw/rtl/double_ended_queue_ring_core.sv]
// ----------------------------------------------------------------------------
// double_ended_queue_ring_core - deque of 32-bit words in a rotating ring
// A row of DEPTH cells forms a ring that, when it moves, shifts one place per
// cycle; the front entry is read and written at cell 0, the back entry at cell DEPTH-1.
//
//   channel   dir   handshake      word
//   in_req    in    valid/ready    req_type, push_value
//   out_rsp   out   valid/ready    status, read_value, entry_total
//
// A request on the same end as the last successful one (or on an empty or
// full deque) executes in the cycle it is accepted if the result register is
// free; its result is registered. A request on the other end first rotates
// the ring the shorter way around to bring that end to its access cell.
// While a result waits, one more request is taken and held until the result
// register frees up. Reset is synchronous; cell contents are not cleared.
// ----------------------------------------------------------------------------
module double_ended_queue_ring_core #(
  parameter int DEPTH = dqr_pkg::DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  dqr_req_if.sink   in_req,
  dqr_rsp_if.source out_rsp
);
  import dqr_pkg::*;

  logic [DATA_W-1:0] cell_q [DEPTH];
  ring_ctl_t         ring_ctl;

  dqr_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_req   (in_req),
    .out_rsp  (out_rsp),
    .front_q  (cell_q[0]),
    .back_q   (cell_q[DEPTH-1]),
    .ring_ctl (ring_ctl)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    cell_ctl_t ctl;

    assign ctl.shift = ring_ctl.shift;
    if (i == 0) begin : g_front
      assign ctl.load = ring_ctl.load_front;
    end else if (i == DEPTH - 1) begin : g_back
      assign ctl.load = ring_ctl.load_back;
    end else begin : g_mid
      assign ctl.load = 1'b0;
    end

    dqr_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .left_q    (cell_q[(i + DEPTH - 1) % DEPTH]),
      .right_q   (cell_q[(i + 1) % DEPTH]),
      .load_data (ring_ctl.load_data),
      .data_q    (cell_q[i])
    );
  end

endmodule
